// ===== rtl/core/comr_pkg.sv =====
// ----------------------------------------------------------------------------
// comr_pkg
// shared widths, result kinds and defaults of the center of mass recenter unit
// ----------------------------------------------------------------------------
package comr_pkg;

    localparam int COMR_MAX_PARTICLES = 32;
    localparam int DATA_W             = 32;
    localparam int NPHASE             = 6;
    localparam int CNT_W              = 6;
    localparam int TOTAL_W            = 40;
    localparam int SUM_W              = 64;
    localparam int FACTOR_W           = 16;
    localparam int IN_W               = DATA_W * (NPHASE + 1);
    localparam int OUT_W              = 264;
    localparam int KIND_W             = 2;

    localparam logic [FACTOR_W-1:0] FACTOR_RESET = 16'd256;

    localparam logic [KIND_W-1:0] KIND_PARTICLE  = 2'd0;
    localparam logic [KIND_W-1:0] KIND_SUMMARY   = 2'd1;
    localparam logic [KIND_W-1:0] KIND_ZERO_MASS = 2'd2;

    typedef struct packed {
        logic start;
        logic done;
    } t_unit_ctl;

endpackage

// ===== rtl/core/center_of_mass_recenter_unit.sv =====
// ----------------------------------------------------------------------------
// center_of_mass_recenter_unit
// loads a set of particles, finds the mass-weighted center and emits every
// particle relative to it, then a summary item with center, mass and radius
// ----------------------------------------------------------------------------
//  channel   direction  handshake                 payload
//  s_axis    in         tvalid / tready           tdata: mass, pos, vel; tlast: last particle
//  m_axis    out        tvalid / tready           tdata: results; tuser: kind; tlast: summary
//  cfg       in         valid / ready             data: radius factor, unsigned q8.8
//
//  loading runs the serial multiplier (one bit a cycle) once per phase component
//  of each stored particle; a dropped particle is not stored
//  after the last particle: serial division per component, then per particle
//  two serial squares plus the output wait, then 32 square root steps and serial
//  scaling before the summary
//  reset is synchronous, active low; no clearing pass, the particle memory is
//  only read at entries written in the current set
//  a stalled output holds the block; input is taken only while loading is idle
// ----------------------------------------------------------------------------
module center_of_mass_recenter_unit #(
    parameter int MAX_PARTICLES = comr_pkg::COMR_MAX_PARTICLES
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    // particle input
    input  logic                            i_s_axis_tvalid,
    output logic                            o_s_axis_tready,
    // mass, pos_x, pos_y, pos_z, vel_x, vel_y, vel_z
    input  logic [comr_pkg::IN_W-1:0]       i_s_axis_tdata,
    // last_particle
    input  logic                            i_s_axis_tlast,
    // result output
    output logic                            o_m_axis_tvalid,
    input  logic                            i_m_axis_tready,
    // mass_out, comp_x, comp_y, comp_z, comp_vx, comp_vy, comp_vz, radius,
    // count, overflow, zero pad
    output logic [comr_pkg::OUT_W-1:0]      o_m_axis_tdata,
    // kind
    output logic [comr_pkg::KIND_W-1:0]     o_m_axis_tuser,
    // last_result
    output logic                            o_m_axis_tlast,
    // radius factor write
    input  logic                            i_cfg_valid,
    output logic                            o_cfg_ready,
    input  logic [comr_pkg::FACTOR_W-1:0]   i_cfg_data
);
    import comr_pkg::*;

    localparam int IDX_W = (MAX_PARTICLES > 1) ? $clog2(MAX_PARTICLES) : 1;
    localparam int J_W   = 3;
    localparam int SQ_N  = 32;

    localparam logic [4:0] S_IDLE     = 5'd0;
    localparam logic [4:0] S_ACC_GO   = 5'd1;
    localparam logic [4:0] S_ACC_WAIT = 5'd2;
    localparam logic [4:0] S_DIV_GO   = 5'd3;
    localparam logic [4:0] S_DIV_WAIT = 5'd4;
    localparam logic [4:0] S_RD       = 5'd5;
    localparam logic [4:0] S_REL      = 5'd6;
    localparam logic [4:0] S_SQX_GO   = 5'd7;
    localparam logic [4:0] S_SQX_WAIT = 5'd8;
    localparam logic [4:0] S_SQY_GO   = 5'd9;
    localparam logic [4:0] S_SQY_WAIT = 5'd10;
    localparam logic [4:0] S_OUT_P    = 5'd11;
    localparam logic [4:0] S_SQRT     = 5'd12;
    localparam logic [4:0] S_SCL_GO   = 5'd13;
    localparam logic [4:0] S_SCL_WAIT = 5'd14;
    localparam logic [4:0] S_OUT_S    = 5'd15;

    logic [4:0]           r_state;
    logic [IN_W-1:0]      r_mem [MAX_PARTICLES];
    logic [IN_W-1:0]      r_in;
    logic [IN_W-1:0]      r_rd;
    logic                 r_last;
    logic [FACTOR_W-1:0]  r_factor;
    logic [TOTAL_W-1:0]   r_total;
    logic [SUM_W-1:0]     r_wsum [NPHASE];
    logic [DATA_W-1:0]    r_cm [NPHASE];
    logic [DATA_W-1:0]    r_rel [NPHASE];
    logic [CNT_W-1:0]     r_count;
    logic [CNT_W-1:0]     r_idx;
    logic [J_W-1:0]       r_j;
    logic [SUM_W-1:0]     r_r2;
    logic [SUM_W-1:0]     r_max;
    logic                 r_dropped;
    logic [SUM_W-1:0]     r_sq_v;
    logic [DATA_W:0]      r_sq_rem;
    logic [DATA_W-1:0]    r_root;
    logic [4:0]           r_sq_step;
    logic                 r_out_valid;
    logic [OUT_W-1:0]     r_out_data;
    logic [KIND_W-1:0]    r_out_kind;
    logic                 r_out_last;

    logic                 w_in_acc;
    logic                 w_out_acc;
    logic                 w_room;
    logic [TOTAL_W:0]     n_total;
    t_unit_ctl            w_mul;
    t_unit_ctl            w_div;
    logic [DATA_W-1:0]    w_mul_a;
    logic [DATA_W-1:0]    w_mul_b;
    logic [SUM_W-1:0]     w_prod;
    logic [SUM_W-1:0]     w_quo;
    logic [DATA_W-1:0]    w_comp;
    logic [DATA_W-1:0]    w_comp_mag;
    logic [SUM_W-1:0]     w_term;
    logic [SUM_W-1:0]     n_wsum;
    logic [SUM_W-1:0]     w_sum_mag;
    logic [DATA_W-1:0]    n_cm;
    logic [DATA_W-1:0]    w_relx_mag;
    logic [DATA_W-1:0]    w_rely_mag;
    logic [SUM_W-1:0]     n_r2;
    logic [DATA_W+2:0]    w_sq_t;
    logic [DATA_W+2:0]    w_sq_trial;
    logic [DATA_W+2:0]    w_sq_diff;
    logic [DATA_W-1:0]    w_scaled;
    logic [DATA_W-1:0]    w_rel_k [NPHASE];

    assign w_in_acc  = i_s_axis_tvalid && o_s_axis_tready;
    assign w_out_acc = r_out_valid && i_m_axis_tready;
    assign w_room    = r_count < CNT_W'(MAX_PARTICLES);
    assign n_total   = {1'b0, r_total} + {{(TOTAL_W - DATA_W + 1){1'b0}},
                                          i_s_axis_tdata[DATA_W-1:0]};

    // phase component j of the particle being accumulated
    assign w_comp     = r_in[DATA_W*(32'(r_j) + 1) +: DATA_W];
    assign w_comp_mag = w_comp[DATA_W-1] ? (DATA_W'(0) - w_comp) : w_comp;
    assign w_term     = w_comp[DATA_W-1] ? (SUM_W'(0) - w_prod) : w_prod;
    assign n_wsum     = r_wsum[r_j] + w_term;

    // magnitude of the weighted sum for the divider
    assign w_sum_mag = r_wsum[r_j][SUM_W-1] ? (SUM_W'(0) - r_wsum[r_j]) : r_wsum[r_j];

    // quotient back to a signed q16.16 center, saturated
    always_comb begin
        if (r_total == '0) begin
            n_cm = '0;
        end else if (r_wsum[r_j][SUM_W-1]) begin
            n_cm = (w_quo >= 64'h0000_0000_8000_0000) ? 32'h8000_0000
                                                      : (DATA_W'(0) - w_quo[DATA_W-1:0]);
        end else begin
            n_cm = (w_quo > 64'h0000_0000_7FFF_FFFF) ? 32'h7FFF_FFFF : w_quo[DATA_W-1:0];
        end
    end

    // relative components, saturated to the signed 32-bit range
    always_comb begin
        logic [DATA_W:0] d;
        for (int k = 0; k < NPHASE; k++) begin
            d = {r_rd[DATA_W*(k+2)-1], r_rd[DATA_W*(k+1) +: DATA_W]}
              - {r_cm[k][DATA_W-1], r_cm[k]};
            if (d[DATA_W] != d[DATA_W-1]) begin
                w_rel_k[k] = d[DATA_W] ? 32'h8000_0000 : 32'h7FFF_FFFF;
            end else begin
                w_rel_k[k] = d[DATA_W-1:0];
            end
        end
    end

    assign w_relx_mag = r_rel[0][DATA_W-1] ? (DATA_W'(0) - r_rel[0]) : r_rel[0];
    assign w_rely_mag = r_rel[1][DATA_W-1] ? (DATA_W'(0) - r_rel[1]) : r_rel[1];
    assign n_r2       = r_r2 + w_prod;

    // square root: two radicand bits per step
    assign w_sq_t     = {r_sq_rem, r_sq_v[SUM_W-1:SUM_W-2]};
    assign w_sq_trial = {1'b0, r_root, 2'b01};
    assign w_sq_diff  = w_sq_t - w_sq_trial;

    // radius times q8.8 factor, dropping eight fraction bits
    assign w_scaled = (w_prod[SUM_W-1:TOTAL_W] != '0) ? '1 : w_prod[TOTAL_W-1:8];

    // shared serial multiplier: accumulation products, squares, scaling
    always_comb begin
        unique case (r_state)
            S_ACC_GO: begin
                w_mul_a = w_comp_mag;
                w_mul_b = r_in[DATA_W-1:0];
            end
            S_SQX_GO: begin
                w_mul_a = w_relx_mag;
                w_mul_b = w_relx_mag;
            end
            S_SQY_GO: begin
                w_mul_a = w_rely_mag;
                w_mul_b = w_rely_mag;
            end
            default: begin
                w_mul_a = r_root;
                w_mul_b = {{(DATA_W - FACTOR_W){1'b0}}, r_factor};
            end
        endcase
    end

    assign w_mul.start = (r_state == S_ACC_GO) || (r_state == S_SQX_GO)
                      || (r_state == S_SQY_GO) || (r_state == S_SCL_GO);
    assign w_div.start = (r_state == S_DIV_GO);

    comr_smul u_smul (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_mul.start),
        .i_a     (w_mul_a),
        .i_b     (w_mul_b),
        .o_done  (w_mul.done),
        .o_prod  (w_prod)
    );

    comr_sdiv u_sdiv (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (w_div.start),
        .i_dividend (w_sum_mag),
        .i_divisor  (r_total),
        .o_done     (w_div.done),
        .o_quo      (w_quo)
    );

    // particle memory: one row of mass and six components per particle
    always_ff @(posedge i_clk) begin
        if (w_in_acc && w_room) begin
            r_mem[r_count[IDX_W-1:0]] <= i_s_axis_tdata;
        end
        if (r_state == S_RD) begin
            r_rd <= r_mem[r_idx[IDX_W-1:0]];
        end
    end

    // radius factor register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_factor <= FACTOR_RESET;
        end else if (i_cfg_valid) begin
            r_factor <= i_cfg_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_total     <= '0;
            r_count     <= '0;
            r_max       <= '0;
            r_dropped   <= 1'b0;
            r_out_valid <= 1'b0;
            r_idx       <= '0;
            r_j         <= '0;
            r_sq_step   <= '0;
            r_last      <= 1'b0;
            for (int k = 0; k < NPHASE; k++) begin
                r_wsum[k] <= '0;
            end
        end else begin
            unique case (r_state)
                S_IDLE: begin
                    if (w_in_acc) begin
                        r_in   <= i_s_axis_tdata;
                        r_last <= i_s_axis_tlast;
                        r_j    <= '0;
                        if (w_room) begin
                            r_count <= r_count + 1'b1;
                            r_total <= n_total[TOTAL_W] ? '1 : n_total[TOTAL_W-1:0];
                            r_state <= S_ACC_GO;
                        end else begin
                            r_dropped <= 1'b1;
                            if (i_s_axis_tlast) begin
                                r_state <= S_DIV_GO;
                            end
                        end
                    end
                end
                S_ACC_GO: begin
                    r_state <= S_ACC_WAIT;
                end
                S_ACC_WAIT: begin
                    if (w_mul.done) begin
                        // saturate when both operands share a sign the sum lost
                        if ((r_wsum[r_j][SUM_W-1] == w_term[SUM_W-1])
                            && (n_wsum[SUM_W-1] != r_wsum[r_j][SUM_W-1])) begin
                            r_wsum[r_j] <= r_wsum[r_j][SUM_W-1] ? {1'b1, {(SUM_W-1){1'b0}}}
                                                                : {1'b0, {(SUM_W-1){1'b1}}};
                        end else begin
                            r_wsum[r_j] <= n_wsum;
                        end
                        if (r_j == J_W'(NPHASE - 1)) begin
                            r_j     <= '0;
                            r_state <= r_last ? S_DIV_GO : S_IDLE;
                        end else begin
                            r_j     <= r_j + 1'b1;
                            r_state <= S_ACC_GO;
                        end
                    end
                end
                S_DIV_GO: begin
                    r_state <= S_DIV_WAIT;
                end
                S_DIV_WAIT: begin
                    if (w_div.done) begin
                        r_cm[r_j] <= n_cm;
                        if (r_j == J_W'(NPHASE - 1)) begin
                            r_j     <= '0;
                            r_idx   <= '0;
                            r_state <= S_RD;
                        end else begin
                            r_j     <= r_j + 1'b1;
                            r_state <= S_DIV_GO;
                        end
                    end
                end
                S_RD: begin
                    if (r_idx == r_count) begin
                        r_sq_v    <= r_max;
                        r_sq_rem  <= '0;
                        r_root    <= '0;
                        r_sq_step <= '0;
                        r_state   <= S_SQRT;
                    end else begin
                        r_state <= S_REL;
                    end
                end
                S_REL: begin
                    for (int k = 0; k < NPHASE; k++) begin
                        r_rel[k] <= w_rel_k[k];
                    end
                    r_state <= S_SQX_GO;
                end
                S_SQX_GO: begin
                    r_state <= S_SQX_WAIT;
                end
                S_SQX_WAIT: begin
                    if (w_mul.done) begin
                        r_r2    <= w_prod;
                        r_state <= S_SQY_GO;
                    end
                end
                S_SQY_GO: begin
                    r_state <= S_SQY_WAIT;
                end
                S_SQY_WAIT: begin
                    if (w_mul.done) begin
                        if (n_r2 > r_max) begin
                            r_max <= n_r2;
                        end
                        r_out_valid <= 1'b1;
                        r_out_kind  <= KIND_PARTICLE;
                        r_out_last  <= 1'b0;
                        r_out_data  <= {1'b0, r_dropped, {CNT_W{1'b0}}, {DATA_W{1'b0}},
                                        r_rel[5], r_rel[4], r_rel[3], r_rel[2],
                                        r_rel[1], r_rel[0], r_rd[DATA_W-1:0]};
                        r_state     <= S_OUT_P;
                    end
                end
                S_OUT_P: begin
                    if (w_out_acc) begin
                        r_out_valid <= 1'b0;
                        r_idx       <= r_idx + 1'b1;
                        r_state     <= S_RD;
                    end
                end
                S_SQRT: begin
                    if (w_sq_t >= w_sq_trial) begin
                        r_sq_rem <= w_sq_diff[DATA_W:0];
                        r_root   <= {r_root[DATA_W-2:0], 1'b1};
                    end else begin
                        r_sq_rem <= w_sq_t[DATA_W:0];
                        r_root   <= {r_root[DATA_W-2:0], 1'b0};
                    end
                    r_sq_v    <= {r_sq_v[SUM_W-3:0], 2'b00};
                    r_sq_step <= r_sq_step + 1'b1;
                    if (r_sq_step == 5'(SQ_N - 1)) begin
                        r_state <= S_SCL_GO;
                    end
                end
                S_SCL_GO: begin
                    r_state <= S_SCL_WAIT;
                end
                S_SCL_WAIT: begin
                    if (w_mul.done) begin
                        r_out_valid <= 1'b1;
                        r_out_kind  <= (r_total == '0) ? KIND_ZERO_MASS : KIND_SUMMARY;
                        r_out_last  <= 1'b1;
                        r_out_data  <= {1'b0, r_dropped, r_count, w_scaled,
                                        r_cm[5], r_cm[4], r_cm[3], r_cm[2], r_cm[1], r_cm[0],
                                        (r_total[TOTAL_W-1:DATA_W] != '0) ? {DATA_W{1'b1}}
                                                                         : r_total[DATA_W-1:0]};
                        r_state     <= S_OUT_S;
                    end
                end
                S_OUT_S: begin
                    if (w_out_acc) begin
                        // set is done: back to an empty run
                        r_out_valid <= 1'b0;
                        r_total     <= '0;
                        r_count     <= '0;
                        r_max       <= '0;
                        r_dropped   <= 1'b0;
                        for (int k = 0; k < NPHASE; k++) begin
                            r_wsum[k] <= '0;
                        end
                        r_state     <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_s_axis_tready = (r_state == S_IDLE);
    assign o_cfg_ready     = 1'b1;
    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = r_out_data;
    assign o_m_axis_tuser  = r_out_kind;
    assign o_m_axis_tlast  = r_out_last;

    // stored particle count stays within capacity
    a_count_cap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(MAX_PARTICLES))
        else $error("particle count beyond capacity");

    // a result is only presented from one of the two output states
    a_out_state: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> (r_state == S_OUT_P || r_state == S_OUT_S))
        else $error("output valid outside an output state");

    // the summary and only the summary ends a run
    a_last_kind: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> (r_out_last == (r_out_kind != KIND_PARTICLE)))
        else $error("last marker and kind disagree");

    // the shared multiplier finishes only while a wait state expects it
    a_mul_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_mul.done |-> (r_state == S_ACC_WAIT || r_state == S_SQX_WAIT
                     || r_state == S_SQY_WAIT || r_state == S_SCL_WAIT))
        else $error("multiplier result with no consumer");

endmodule

// ===== rtl/core/comr_smul.sv =====
// ----------------------------------------------------------------------------
// comr_smul
// bit-serial unsigned 32x32 multiplier, one multiplier bit per cycle
// ----------------------------------------------------------------------------
module comr_smul (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_start,
    input  logic [comr_pkg::DATA_W-1:0]    i_a,
    input  logic [comr_pkg::DATA_W-1:0]    i_b,
    output logic                           o_done,
    output logic [2*comr_pkg::DATA_W-1:0]  o_prod
);
    import comr_pkg::*;

    localparam int STEP_W = $clog2(DATA_W);

    logic [DATA_W-1:0] r_a;
    logic [DATA_W-1:0] r_hi;
    logic [DATA_W-1:0] r_lo;
    logic [STEP_W-1:0] r_step;
    logic              r_busy;
    logic              r_done;
    logic [DATA_W:0]   w_sum;

    // add the multiplicand when the low bit is set, then shift the pair right
    assign w_sum = {1'b0, r_hi} + (r_lo[0] ? {1'b0, r_a} : '0);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_step <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_a    <= i_a;
                r_hi   <= '0;
                r_lo   <= i_b;
                r_step <= '0;
                r_busy <= 1'b1;
            end else if (r_busy) begin
                r_hi   <= w_sum[DATA_W:1];
                r_lo   <= {w_sum[0], r_lo[DATA_W-1:1]};
                r_step <= r_step + 1'b1;
                if (r_step == STEP_W'(DATA_W - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_done = r_done;
    assign o_prod = {r_hi, r_lo};

endmodule

// ===== rtl/core/comr_sdiv.sv =====
// ----------------------------------------------------------------------------
// comr_sdiv
// restoring divider, 64-bit dividend by 40-bit divisor, one quotient bit a cycle
// ----------------------------------------------------------------------------
module comr_sdiv (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_start,
    input  logic [comr_pkg::SUM_W-1:0]    i_dividend,
    input  logic [comr_pkg::TOTAL_W-1:0]  i_divisor,
    output logic                          o_done,
    output logic [comr_pkg::SUM_W-1:0]    o_quo
);
    import comr_pkg::*;

    localparam int STEP_W = $clog2(SUM_W);

    logic [TOTAL_W-1:0] r_div;
    logic [TOTAL_W-1:0] r_rem;
    logic [SUM_W-1:0]   r_quo;
    logic [STEP_W-1:0]  r_step;
    logic               r_busy;
    logic               r_done;
    logic [TOTAL_W:0]   w_trial;
    logic [TOTAL_W:0]   w_diff;
    logic               w_ge;

    // bring down the next dividend bit, subtract when it fits
    assign w_trial = {r_rem, r_quo[SUM_W-1]};
    assign w_diff  = w_trial - {1'b0, r_div};
    assign w_ge    = w_trial >= {1'b0, r_div};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_step <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_div  <= i_divisor;
                r_rem  <= '0;
                r_quo  <= i_dividend;
                r_step <= '0;
                r_busy <= 1'b1;
            end else if (r_busy) begin
                r_rem  <= w_ge ? w_diff[TOTAL_W-1:0] : w_trial[TOTAL_W-1:0];
                r_quo  <= {r_quo[SUM_W-2:0], w_ge};
                r_step <= r_step + 1'b1;
                if (r_step == STEP_W'(SUM_W - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_done = r_done;
    assign o_quo  = r_quo;

endmodule
